[rtl/cbld_pkg.sv]
// Shared types, request codes and default sizes for the circular list deque.
package cbld_pkg;

  localparam int unsigned NumBufsDefault  = 256;
  localparam int unsigned NumListsDefault = 4;

  // Field widths of the stream words.
  localparam int unsigned ReqW   = 3;
  localparam int unsigned ListW  = 2;
  localparam int unsigned ItemW  = 8;
  localparam int unsigned CountW = 9;

  typedef enum logic [ReqW-1:0] {
    REQ_CLEAR     = 3'd0,
    REQ_PUSH_HEAD = 3'd1,
    REQ_PUSH_TAIL = 3'd2,
    REQ_POP_HEAD  = 3'd3,
    REQ_POP_TAIL  = 3'd4,
    REQ_REMOVE    = 3'd5
  } cbld_req_e;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [CountW-1:0] list_count;
    logic              list_empty;
    logic [ItemW-1:0]  head_after;
    logic              item_valid;
    logic [ItemW-1:0]  item_out;
  } cbld_res_t;

endpackage

[rtl/circular_buffer_list_deque.sv]
// Top level of the circular doubly linked list deque over a shared buffer pool.
//
//   Channel   Direction  Signals                      Contents of one word
//   s_axis    in         tvalid, tready, tdata, tuser one request
//   m_axis    out        tvalid, tready, tdata, tuser one result
//
// Every request runs the execute step. A pop from the tail of a non-empty list
// first needs a second dependent read to find the tail's links; a push to a
// non-empty list adds a second link write step, since each link store has a
// single write port and such a push writes two links to each.
// Reset empties every list at once; the link stores need no clearing pass.
// A finished result waits in the output register; a new word is taken while it
// waits, and the block stalls at the end of that word only if the old result
// is still not taken.
module circular_buffer_list_deque
  import cbld_pkg::*;
#(
  parameter int unsigned NUM_BUFS  = NumBufsDefault,
  parameter int unsigned NUM_LISTS = NumListsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] item_index
  input  logic [4:0]  s_axis_tuser,  // [2:0] req_type, [4:3] list_id
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] item_out, [15:8] head_after,
                                     // [16] list_empty, [25:17] list_count
  output logic        m_axis_tuser   // [0] item_valid
);

  localparam int unsigned BufAw  = (NUM_BUFS > 1) ? $clog2(NUM_BUFS) : 1;
  localparam int unsigned ListAw = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned CntW   = $clog2(NUM_BUFS + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAIL = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_WR2  = 3'd3;
  localparam logic [2:0] S_HOLD = 3'd4;

  // Fold an item index into the pool by restoring subtraction of shifted sizes.
  function automatic logic [BufAw-1:0] buf_idx(input logic [ItemW-1:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = ItemW - 1; k >= 0; k--) begin
      if (r >= (32'(NUM_BUFS) << k)) begin
        r = r - (32'(NUM_BUFS) << k);
      end
    end
    return BufAw'(r);
  endfunction

  // The same folding for the list number.
  function automatic logic [ListAw-1:0] list_idx(input logic [ListW-1:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = ListW - 1; k >= 0; k--) begin
      if (r >= (32'(NUM_LISTS) << k)) begin
        r = r - (32'(NUM_LISTS) << k);
      end
    end
    return ListAw'(r);
  endfunction

  // Per-list head, non-empty flag and count live in flip-flops.
  logic [BufAw-1:0]  head_q [NUM_LISTS];
  logic [NUM_LISTS-1:0] pres_q;
  logic [CntW-1:0]   cnt_q  [NUM_LISTS];

  logic [2:0]        state_q, state_d;
  logic [ReqW-1:0]   req_q;
  logic [ListAw-1:0] list_q;
  logic [BufAw-1:0]  item_q;
  logic [BufAw-1:0]  node_q;
  logic [BufAw-1:0]  w2n_q, w2p_q;
  cbld_res_t         res_q, res_d;
  cbld_res_t         out_q;
  logic              out_valid_q;

  // Incoming word, already folded into range.
  logic [ReqW-1:0]   in_req;
  logic [ListAw-1:0] in_list;
  logic [BufAw-1:0]  in_item;
  logic              accept;

  assign in_req  = s_axis_tuser[2:0];
  assign in_list = list_idx(s_axis_tuser[4:3]);
  assign in_item = buf_idx(s_axis_tdata[7:0]);

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Link store ports.
  logic              rd_en;
  logic [BufAw-1:0]  rd_addr;
  logic [BufAw-1:0]  next_rd, prev_rd;
  logic              nwe, pwe;
  logic [BufAw-1:0]  nwaddr, nwdata, pwaddr, pwdata;

  // A removal looks at the named item; everything else starts at the head.
  // A pop from the tail reads again at the tail found in the head's prev link.
  assign rd_en   = accept || (state_q == S_TAIL);
  assign rd_addr = (state_q == S_TAIL) ? prev_rd :
                   ((in_req == REQ_REMOVE) ? in_item : head_q[in_list]);

  cbld_link_mem #(
    .DEPTH (NUM_BUFS),
    .WIDTH (BufAw)
  ) u_next_mem (
    .clk_i   (clk_i),
    .we_i    (nwe),
    .waddr_i (nwaddr),
    .wdata_i (nwdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (next_rd)
  );

  cbld_link_mem #(
    .DEPTH (NUM_BUFS),
    .WIDTH (BufAw)
  ) u_prev_mem (
    .clk_i   (clk_i),
    .we_i    (pwe),
    .waddr_i (pwaddr),
    .wdata_i (pwdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (prev_rd)
  );

  // Execute step: the links of the target node are now in the read registers.
  logic [BufAw-1:0] cur_head, head_n, got;
  logic             cur_pres, pres_n, vld, need_wr2;
  logic [CntW-1:0]  cur_cnt, cnt_n, cnt_dn;
  logic             out_free, out_load;

  assign cur_head = head_q[list_q];
  assign cur_pres = pres_q[list_q];
  assign cur_cnt  = cnt_q[list_q];
  assign cnt_dn   = (cur_cnt != '0) ? cur_cnt - 1'b1 : cur_cnt;

  always_comb begin
    head_n   = cur_head;
    pres_n   = cur_pres;
    cnt_n    = cur_cnt;
    got      = '0;
    vld      = 1'b0;
    need_wr2 = 1'b0;
    nwe      = 1'b0;
    pwe      = 1'b0;
    nwaddr   = item_q;
    nwdata   = item_q;
    pwaddr   = item_q;
    pwdata   = item_q;
    if (state_q == S_EXEC) begin
      unique case (req_q) inside
        REQ_CLEAR: begin
          pres_n = 1'b0;
          cnt_n  = '0;
        end
        REQ_PUSH_HEAD, REQ_PUSH_TAIL: begin
          got = item_q;
          vld = 1'b1;
          nwe = 1'b1;
          pwe = 1'b1;
          if (!cur_pres) begin
            // A lone item links to itself.
            head_n = item_q;
            pres_n = 1'b1;
            cnt_n  = CntW'(1);
          end else begin
            // First the new item's own links; the neighbors follow next cycle.
            nwdata   = cur_head;
            pwdata   = prev_rd;
            need_wr2 = 1'b1;
            // A tail push leaves the head on the item that was the tail,
            // which is the item itself when it already was the head.
            head_n = ((req_q == REQ_PUSH_HEAD) || (item_q == cur_head)) ? item_q : prev_rd;
            cnt_n  = (cur_cnt < CntW'(NUM_BUFS)) ? cur_cnt + 1'b1 : cur_cnt;
          end
        end
        REQ_POP_HEAD, REQ_POP_TAIL, REQ_REMOVE: begin
          if (cur_pres) begin
            // Unlink the target node: its neighbors point past it.
            pwe    = 1'b1;
            pwaddr = next_rd;
            pwdata = prev_rd;
            nwe    = 1'b1;
            nwaddr = prev_rd;
            nwdata = next_rd;
            got    = node_q;
            vld    = 1'b1;
            cnt_n  = cnt_dn;
            pres_n = (cnt_dn != '0);
            head_n = ((req_q == REQ_REMOVE) && (item_q != cur_head)) ? cur_head : next_rd;
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == S_WR2) begin
      nwe    = 1'b1;
      nwaddr = w2n_q;
      pwe    = 1'b1;
      pwaddr = w2p_q;
    end
  end

  always_comb begin
    res_d            = '0;
    res_d.item_out   = vld ? 8'(got) : '0;
    res_d.item_valid = vld;
    res_d.head_after = pres_n ? 8'(head_n) : '0;
    res_d.list_empty = !pres_n;
    res_d.list_count = 9'(cnt_n);
  end

  assign out_free = !out_valid_q || m_axis_tready;

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = ((in_req == REQ_POP_TAIL) && pres_q[in_list]) ? S_TAIL : S_EXEC;
        end
      end
      S_TAIL: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (need_wr2) begin
          state_d = S_WR2;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_WR2, S_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pres_q      <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_EXEC) begin
        head_q[list_q] <= head_n;
        pres_q[list_q] <= pres_n;
        cnt_q[list_q]  <= cnt_n;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_req;
      list_q <= in_list;
      item_q <= in_item;
      node_q <= (in_req == REQ_REMOVE) ? in_item : head_q[in_list];
    end
    if (state_q == S_TAIL) begin
      node_q <= prev_rd;
    end
    if (state_q == S_EXEC) begin
      res_q <= res_d;
      w2n_q <= prev_rd;
      w2p_q <= cur_head;
    end
    if (out_load) begin
      out_q <= (state_q == S_EXEC) ? res_d : res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.item_valid;
  assign m_axis_tdata  = {6'b0, out_q.list_count, out_q.list_empty,
                          out_q.head_after, out_q.item_out};

  // A list is marked non-empty exactly when its count is nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> (pres_q[list_q] == (cnt_q[list_q] != '0)))
    else $error("list present flag disagrees with its count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> (cnt_q[list_q] <= CntW'(NUM_BUFS)))
    else $error("list count exceeds the pool size");

  // The second link write only ever follows the execute step of a push.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR2) |->
      (($past(state_q) == S_EXEC) && ((req_q == REQ_PUSH_HEAD) || (req_q == REQ_PUSH_TAIL))))
    else $error("second link write outside a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL) |-> ((req_q == REQ_POP_TAIL) && pres_q[list_q]))
    else $error("tail lookup outside a pop from a non-empty list");

  // A result is only produced for a word in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q != S_IDLE) && (state_q != S_TAIL))
    else $error("result loaded with no word in flight");

endmodule

[rtl/cbld_link_mem.sv]
// Link store: one write port, one read port, registered read data.
module cbld_link_mem
  import cbld_pkg::*;
#(
  parameter int unsigned DEPTH = NumBufsDefault,
  parameter int unsigned WIDTH = $clog2(NumBufsDefault)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
